### sv/rdc_pkg.sv
// Shared constants, types and the digit glyph lookup for the radix digit converter.
// No dependencies; used by rdc_cell_row and radix_digit_converter.
package rdc_pkg;

  localparam int DEF_VALUE_BITS = 32;
  localparam int DEF_MAX_DIGITS = 32;

  localparam int RADIX_W = 6;
  localparam int CHAR_W  = 7;
  localparam int TOTAL_W = 6;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

  localparam logic [RADIX_W-1:0] DIGIT_TOP  = RADIX_W'(35);
  localparam logic [RADIX_W-1:0] DECIMAL_N  = RADIX_W'(10);
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = CHAR_W'(48);  // '0'
  localparam logic [CHAR_W-1:0]  CHAR_ALPHA = CHAR_W'(55);  // 'A' - 10

  // Control group from the sequencer to the digit cell row.
  typedef struct packed {
    logic clear;
    logic shift;
    logic bit_in;
  } rdc_row_ctl_t;

  // Digit value to ASCII: 0-9 then A-Z.
  function automatic logic [CHAR_W-1:0] glyph(input logic [RADIX_W-1:0] d);
    logic [RADIX_W-1:0] dc;
    dc = (d > DIGIT_TOP) ? DIGIT_TOP : d;
    if (dc < DECIMAL_N) begin
      glyph = CHAR_ZERO + CHAR_W'(dc);
    end else begin
      glyph = CHAR_ALPHA + CHAR_W'(dc);
    end
  endfunction

endpackage

### sv/radix_digit_converter.sv
// Sequence: the value is shifted bit-serially into the digit cells (S_CONV), the digit count
// and read pointer are set (S_LOAD), then one digit per cycle is emitted (S_EMIT) while the
// receiver accepts them; a held-off out_ready stalls it. A new request is taken only in idle,
// after the last digit of the previous value has been loaded into the output register.
// Reset: radix returns to 10, sequencer idle, no result pending.
// Top level of the radix digit converter; uses rdc_pkg and rdc_cell_row.
module radix_digit_converter #(
  parameter int VALUE_BITS = rdc_pkg::DEF_VALUE_BITS,
  parameter int MAX_DIGITS = rdc_pkg::DEF_MAX_DIGITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [rdc_pkg::RADIX_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [VALUE_BITS-1:0]         value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rdc_pkg::CHAR_W-1:0]    digit_char,
  output logic [rdc_pkg::TOTAL_W-1:0]   digit_total,
  output logic                          last
);

  localparam int RW = rdc_pkg::RADIX_W;
  localparam int BW = $clog2(VALUE_BITS);
  localparam int IW = $clog2(MAX_DIGITS);
  localparam int LW = $clog2(MAX_DIGITS + 1);

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_LOAD, S_EMIT} state_t;

  state_t                  state;
  logic [RW-1:0]           radix;
  logic [VALUE_BITS-1:0]   vshift;
  logic [BW-1:0]           bit_cnt;
  logic [LW-1:0]           count;
  logic [IW-1:0]           ptr;
  logic [LW-1:0]           row_len;
  logic [RW-1:0]           rd_digit;
  rdc_pkg::rdc_row_ctl_t   row_ctl;
  logic                    in_take;
  logic                    out_free;

  assign in_ready = (state == S_IDLE);
  assign in_take  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign row_ctl.clear  = in_take;
  assign row_ctl.shift  = (state == S_CONV);
  assign row_ctl.bit_in = vshift[VALUE_BITS-1];

  rdc_cell_row #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_row (
    .clk     (clk),
    .rst     (rst),
    .ctl     (row_ctl),
    .radix   (radix),
    .rd_index(ptr),
    .rd_digit(rd_digit),
    .len     (row_len)
  );

  // Radix register, clamped on write
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= rdc_pkg::RADIX_RESET;
    end else if (cfg_write) begin
      priority if (cfg_data < rdc_pkg::RADIX_MIN) begin
        radix <= rdc_pkg::RADIX_MIN;
      end else if (cfg_data > rdc_pkg::RADIX_MAX) begin
        radix <= rdc_pkg::RADIX_MAX;
      end else begin
        radix <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // while emitting, the digit load below owns out_valid
      if (out_valid && out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            vshift  <= value;
            bit_cnt <= BW'(VALUE_BITS - 1);
            state   <= S_CONV;
          end
        end
        S_CONV: begin
          vshift  <= vshift << 1;
          bit_cnt <= bit_cnt - BW'(1);
          if (bit_cnt == '0) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          // zero value still gives one digit
          if (row_len == '0) begin
            count <= LW'(1);
            ptr   <= '0;
          end else begin
            count <= row_len;
            ptr   <= IW'(row_len - LW'(1));
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            digit_char  <= rdc_pkg::glyph(rd_digit);
            digit_total <= rdc_pkg::TOTAL_W'(count);
            last        <= (ptr == '0);
            if (ptr == '0) begin
              state <= S_IDLE;
            end else begin
              ptr <= ptr - IW'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_radix_range: assert property (@(posedge clk) disable iff (rst)
    radix >= rdc_pkg::RADIX_MIN && radix <= rdc_pkg::RADIX_MAX)
    else $error("radix register outside 2..36");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_take |=> !in_ready)
    else $error("second request taken during a conversion");

  a_ptr_in_count: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> (LW'(ptr) < count))
    else $error("digit pointer beyond digit count");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digit_char) &&
      $stable(digit_total) && $stable(last))
    else $error("pending digit changed before accept");

endmodule

### sv/rdc_cell_row.sv
// Row of radix digit cells; the value enters MSB first, one bit per cycle while ctl.shift is set,
// each cell doubling its digit plus the carry from below. Uses rdc_pkg.
module rdc_cell_row #(
  parameter int MAX_DIGITS = rdc_pkg::DEF_MAX_DIGITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rdc_pkg::rdc_row_ctl_t             ctl,
  input  logic [rdc_pkg::RADIX_W-1:0]       radix,
  input  logic [$clog2(MAX_DIGITS)-1:0]     rd_index,
  output logic [rdc_pkg::RADIX_W-1:0]       rd_digit,
  output logic [$clog2(MAX_DIGITS+1)-1:0]   len
);

  localparam int RW = rdc_pkg::RADIX_W;
  localparam int LW = $clog2(MAX_DIGITS + 1);

  logic [RW-1:0] cells      [MAX_DIGITS];
  logic [RW-1:0] cells_next [MAX_DIGITS];
  logic [MAX_DIGITS:0] carry;
  logic [RW-1:0] thr0;
  logic [RW-1:0] thr1;
  logic [LW-1:0] len_next;

  // 2d+c >= r  <=>  d >= ceil((r-c)/2)
  assign thr0 = (radix + RW'(1)) >> 1;
  assign thr1 = radix >> 1;

  always_comb begin
    logic [RW:0] dbl;
    carry[0] = ctl.bit_in;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      carry[i+1] = carry[i] ? (cells[i] >= thr1) : (cells[i] >= thr0);
      dbl = {cells[i], carry[i]} - (carry[i+1] ? {1'b0, radix} : '0);
      cells_next[i] = dbl[RW-1:0];
    end
  end

  // A new top digit appears when the carry reaches the first empty cell.
  always_comb begin
    len_next = len;
    if (len != LW'(MAX_DIGITS) && carry[len]) begin
      len_next = len + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
        cells[i] <= '0;
      end
    end else if (ctl.shift) begin
      cells <= cells_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      len <= '0;
    end else if (ctl.shift) begin
      len <= len_next;
    end
  end

  assign rd_digit = cells[rd_index];

endmodule

### tb/sv/radix_digit_converter_tb.sv
// Self-checking testbench for radix_digit_converter: predicts the digit string for each
// accepted value at the current radix and checks every digit result in order.
// Depends on rdc_pkg and the radix_digit_converter RTL.
module radix_digit_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VBITS       = rdc_pkg::DEF_VALUE_BITS;
  localparam int NDIG        = rdc_pkg::DEF_MAX_DIGITS;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 4000;
  localparam int SETTLE      = 8;

  typedef struct {
    logic [rdc_pkg::CHAR_W-1:0]  ch;
    logic [rdc_pkg::TOTAL_W-1:0] total;
    logic                        last;
  } digit_rec_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_write = 1'b0;
  logic [rdc_pkg::RADIX_W-1:0]  cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [VBITS-1:0]             value = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [rdc_pkg::CHAR_W-1:0]   digit_char;
  logic [rdc_pkg::TOTAL_W-1:0]  digit_total;
  logic                         last;

  digit_rec_t                   expected_digits[$];
  digit_rec_t                   want;
  logic [rdc_pkg::RADIX_W-1:0]  base_now = rdc_pkg::RADIX_RESET;
  int                           mismatch_count = 0;
  int                           burst_left = 0;
  bit                           steady = 1'b0;
  int                           hold_req = 0;
  int                           hold_seen = 0;
  int                           hold_left = 0;
  int                           stall_mode = 0;
  int                           stall_timer = 0;
  int                           idle_cycles = 0;

  radix_digit_converter uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digit_char  (digit_char),
    .digit_total (digit_total),
    .last        (last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Digits are produced least significant first, then queued most significant first.
  function automatic void predict_digits(input logic [VBITS-1:0] v,
                                         input logic [rdc_pkg::RADIX_W-1:0] base);
    logic [rdc_pkg::RADIX_W-1:0] digs [NDIG];
    logic [VBITS-1:0]            rest;
    int                          n;
    digit_rec_t                  rec;
    rest = v;
    n = 0;
    if (rest == '0) begin
      digs[0] = '0;
      n = 1;
    end else begin
      while (rest != '0 && n < NDIG) begin
        digs[n] = rdc_pkg::RADIX_W'(rest % base);
        rest = rest / base;
        n++;
      end
    end
    for (int k = n - 1; k >= 0; k--) begin
      if (digs[k] < rdc_pkg::DECIMAL_N)
        rec.ch = rdc_pkg::CHAR_ZERO + rdc_pkg::CHAR_W'(digs[k]);
      else
        rec.ch = rdc_pkg::CHAR_ALPHA + rdc_pkg::CHAR_W'(digs[k]);
      rec.total = rdc_pkg::TOTAL_W'(n);
      rec.last  = (k == 0);
      expected_digits.push_back(rec);
    end
  endfunction

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", what);
  endtask

  // Sends one request; unless steady is set, bursts of random length separated by random gaps.
  task automatic offer_value(input logic [VBITS-1:0] v);
    int gap;
    if (!steady && burst_left == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    predict_digits(v, base_now);
  endtask

  task automatic wait_idle(input int settle);
    in_valid <= 1'b0;
    while (expected_digits.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_radix(input logic [rdc_pkg::RADIX_W-1:0] w);
    wait_idle(SETTLE);
    cfg_write <= 1'b1;
    cfg_data  <= w;
    @(posedge clk);
    cfg_write <= 1'b0;
    base_now = (w < rdc_pkg::RADIX_MIN) ? rdc_pkg::RADIX_MIN :
               (w > rdc_pkg::RADIX_MAX) ? rdc_pkg::RADIX_MAX : w;
  endtask

  // Mixes zero, all ones, powers of the base and their predecessors with random widths.
  function automatic logic [VBITS-1:0] pick_value();
    logic [63:0] p;
    int          sel;
    int          nb;
    sel = $urandom_range(0, 9);
    case (sel)
      0: pick_value = '0;
      1: pick_value = '1;
      2, 3: begin
        p = 64'd1;
        repeat ($urandom_range(1, VBITS))
          if (p * base_now <= 64'hFFFF_FFFF) p = p * base_now;
        pick_value = (sel == 2) ? VBITS'(p) : VBITS'(p - 64'd1);
      end
      default: begin
        nb = $urandom_range(1, VBITS);
        pick_value = VBITS'($urandom) & VBITS'((64'd1 << nb) - 64'd1);
      end
    endcase
  endfunction

  task automatic test_default_radix();
    offer_value(32'd0);
    offer_value(32'd1);
    offer_value(32'd9);
    offer_value(32'd10);
    offer_value(32'd1000000000);
    offer_value(32'hFFFF_FFFF);
  endtask

  task automatic test_radix_clamp();
    set_radix(6'd0);
    offer_value(32'd5);
    set_radix(6'd1);
    offer_value(32'hFFFF_FFFF);  // 32 binary digits
    set_radix(6'd37);
    offer_value(32'd35);
    offer_value(32'd36);
    set_radix(6'd63);
    offer_value(32'd1295);
    offer_value(32'hFFFF_FFFF);
  endtask

  task automatic test_extremes();
    set_radix(6'd2);
    offer_value(32'h8000_0000);
    offer_value(32'h5555_5555);
    offer_value(32'd0);
    set_radix(6'd36);
    offer_value(32'd0);
    offer_value(32'hAAAA_AAAA);
    set_radix(6'd16);
    offer_value(32'hDEAD_BEEF);
    offer_value(32'hFFFF_FFFF);
    set_radix(6'd35);
    offer_value(32'd34);
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 0) set_radix(6'd2);
      else if (ph == 1) set_radix(6'd36);
      else set_radix(rdc_pkg::RADIX_W'($urandom_range(0, 63)));
      steady = (ph % 4 == 3);
      repeat (27) offer_value(pick_value());
    end
    steady = 1'b0;
  endtask

  // Receiver holds off while requests keep coming, so the block backs up.
  task automatic test_backpressure();
    set_radix(6'd2);
    steady = 1'b1;
    hold_req++;
    repeat (20) offer_value(VBITS'($urandom));
    steady = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_digits.size() == 0) begin
        note_mismatch($sformatf("unexpected digit char=%0d total=%0d last=%0b",
                                digit_char, digit_total, last));
      end else begin
        want = expected_digits.pop_front();
        if (digit_char !== want.ch || digit_total !== want.total || last !== want.last)
          note_mismatch($sformatf("exp char=%0d total=%0d last=%0b, got char=%0d total=%0d last=%0b",
                                  want.ch, want.total, want.last,
                                  digit_char, digit_total, last));
      end
    end
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (stall_timer == 0) begin
      stall_mode  = $urandom_range(0, 3);
      stall_timer = $urandom_range(20, 120);
    end else begin
      stall_timer--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= 1'(stall_timer >> 3);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_default_radix();
    test_radix_clamp();
    test_extremes();
    test_random_phases();
    test_backpressure();
    wait_idle(70);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
sv/rdc_pkg.sv
sv/rdc_cell_row.sv
sv/radix_digit_converter.sv
tb/sv/radix_digit_converter_tb.sv
